// ===== hw/rtl/bsf_pkg.sv =====
package bsf_pkg;

    localparam int COORD_W        = 16;
    localparam int JAC_W          = 32;
    localparam int OUT_W          = 32;
    localparam int COORD_FRAC     = COORD_W / 2;
    localparam int FRAC_BITS      = 16;
    localparam int SHAPE_SHIFT    = 2 * FRAC_BITS - 2 * COORD_FRAC - 1;
    localparam int DERIV_SHIFT    = 2 * FRAC_BITS - COORD_FRAC - 1;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int PPROD_W        = DIFF_W + COORD_W;
    localparam int SUM_W          = PPROD_W + 2;
    localparam int MAG_W          = SUM_W - 1;
    localparam int NUM_W          = MAG_W + SHAPE_SHIFT;
    localparam int DEN_W          = JAC_W;
    localparam int LANES          = 9;
    localparam int SHAPE_LANES    = 3;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = OUT_W / BITS_PER_STAGE;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] num_mag;
        logic [LANES-1:0]            neg;
        logic [DEN_W-1:0]            den;
        logic                        zero;
    } front_out_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [OUT_W-1:0] word;
        logic             ovf;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        logic [LANES-1:0][OUT_W-1:0] word;
        logic [LANES-1:0]            ovf;
        logic [LANES-1:0]            neg;
        logic                        zero;
    } div_out_t;

    // Restoring division over BITS_PER_STAGE quotient bits. Quotient bits shift
    // in at the bottom of the word while dividend bits shift out at its top.
    function automatic div_lane_t div_step(div_lane_t l, logic [DEN_W-1:0] d);
        logic [DEN_W:0] t;
        div_lane_t      r;
        r = l;
        for (int b = 0; b < BITS_PER_STAGE; b++)
        begin
            t      = {r.rem, r.word[OUT_W-1]};
            r.word = {r.word[OUT_W-2:0], 1'b0};
            if (t >= {1'b0, d})
            begin
                t         = t - {1'b0, d};
                r.word[0] = 1'b1;
            end
            r.rem = t[DEN_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bsf_if.sv =====
interface bsf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bsf_pkg::COORD_W-1:0]  vert0_x;
    logic signed [bsf_pkg::COORD_W-1:0]  vert0_y;
    logic signed [bsf_pkg::COORD_W-1:0]  vert1_x;
    logic signed [bsf_pkg::COORD_W-1:0]  vert1_y;
    logic signed [bsf_pkg::COORD_W-1:0]  vert2_x;
    logic signed [bsf_pkg::COORD_W-1:0]  vert2_y;
    logic signed [bsf_pkg::COORD_W-1:0]  point_x;
    logic signed [bsf_pkg::COORD_W-1:0]  point_y;
    logic signed [bsf_pkg::JAC_W-1:0]    area_jacobian;

    modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                    point_x, point_y, area_jacobian, input ready);
    modport sink (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
                  point_x, point_y, area_jacobian, output ready);
endinterface

interface bsf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [bsf_pkg::OUT_W-1:0]  shape0;
    logic signed [bsf_pkg::OUT_W-1:0]  shape1;
    logic signed [bsf_pkg::OUT_W-1:0]  shape2;
    logic signed [bsf_pkg::OUT_W-1:0]  dshape0_dx;
    logic signed [bsf_pkg::OUT_W-1:0]  dshape0_dy;
    logic signed [bsf_pkg::OUT_W-1:0]  dshape1_dx;
    logic signed [bsf_pkg::OUT_W-1:0]  dshape1_dy;
    logic signed [bsf_pkg::OUT_W-1:0]  dshape2_dx;
    logic signed [bsf_pkg::OUT_W-1:0]  dshape2_dy;
    logic                              zero_divisor;

    modport source (output valid, shape0, shape1, shape2, dshape0_dx, dshape0_dy,
                    dshape1_dx, dshape1_dy, dshape2_dx, dshape2_dy, zero_divisor,
                    input ready);
    modport sink (input valid, shape0, shape1, shape2, dshape0_dx, dshape0_dy,
                  dshape1_dx, dshape1_dy, dshape2_dx, dshape2_dy, zero_divisor,
                  output ready);
endinterface

// ===== hw/rtl/triangle_barycentric_shape_functions.sv =====
// An accepted item passes front stages A to C, the divider stages and the output register.
// Throughput: one item per cycle while not stalled; the nine lanes of the pipelined
// restoring divider each retire two quotient bits per stage over sixteen stages.
// Reset: rst_n clears all valid bits asynchronously; the data path is not reset.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
module triangle_barycentric_shape_functions (
    input  logic      clk,
    input  logic      rst_n,
    bsf_in_if.sink    sample,
    bsf_out_if.source result
);
    import bsf_pkg::*;

    // The pipeline moves as a whole whenever the output register is empty or
    // its item is being taken.
    logic adv;

    logic signed [COORD_W-1:0] vx [3];
    logic signed [COORD_W-1:0] vy [3];

    logic       fe_valid;
    front_out_t fe_data;
    logic       dv_valid;
    div_out_t   dv_data;

    logic                        out_valid_reg;
    logic [LANES-1:0][OUT_W-1:0] res_reg;
    logic [LANES-1:0][OUT_W-1:0] res_next;
    logic                        zero_reg;

    assign adv          = !out_valid_reg || result.ready;
    assign sample.ready = adv;

    assign vx[0] = sample.vert0_x;
    assign vy[0] = sample.vert0_y;
    assign vx[1] = sample.vert1_x;
    assign vy[1] = sample.vert1_y;
    assign vx[2] = sample.vert2_x;
    assign vy[2] = sample.vert2_y;

    bsf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sample.valid),
        .vx        (vx),
        .vy        (vy),
        .px        (sample.point_x),
        .py        (sample.point_y),
        .jac       (sample.area_jacobian),
        .out_valid (fe_valid),
        .out_data  (fe_data)
    );

    bsf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fe_valid),
        .in_data   (fe_data),
        .out_valid (dv_valid),
        .out_data  (dv_data)
    );

    // Saturate each quotient magnitude to the signed range, apply the sign,
    // and force everything to zero when the Jacobian is zero.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [OUT_W-1:0] lim;
            logic [OUT_W-1:0] mag;
            lim = dv_data.neg[l] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
            mag = (dv_data.ovf[l] || dv_data.word[l] > lim) ? lim : dv_data.word[l];
            if (dv_data.zero)
            begin
                res_next[l] = '0;
            end
            else
            begin
                res_next[l] = dv_data.neg[l] ? OUT_W'(~mag + 1'b1) : mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg  <= res_next;
            zero_reg <= dv_data.zero;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.shape0       = res_reg[0];
    assign result.shape1       = res_reg[1];
    assign result.shape2       = res_reg[2];
    assign result.dshape0_dx   = res_reg[3];
    assign result.dshape0_dy   = res_reg[4];
    assign result.dshape1_dx   = res_reg[5];
    assign result.dshape1_dy   = res_reg[6];
    assign result.dshape2_dx   = res_reg[7];
    assign result.dshape2_dy   = res_reg[8];
    assign result.zero_divisor = zero_reg;

endmodule

// ===== hw/rtl/bsf_front.sv =====
module bsf_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic signed [bsf_pkg::COORD_W-1:0] vx [3],
    input  logic signed [bsf_pkg::COORD_W-1:0] vy [3],
    input  logic signed [bsf_pkg::COORD_W-1:0] px,
    input  logic signed [bsf_pkg::COORD_W-1:0] py,
    input  logic signed [bsf_pkg::JAC_W-1:0]   jac,
    output logic                               out_valid,
    output bsf_pkg::front_out_t                out_data
);
    import bsf_pkg::*;

    // Stage A: inputs and edge differences.
    logic                      va_reg;
    logic signed [COORD_W-1:0] vx_reg [3];
    logic signed [COORD_W-1:0] vy_reg [3];
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [JAC_W-1:0]   jac_a_reg;
    logic signed [DIFF_W-1:0]  dy_a_reg [3];
    logic signed [DIFF_W-1:0]  dx_a_reg [3];

    // Stage B: products.
    logic                      vb_reg;
    logic signed [PROD_W-1:0]  c1_reg [3];
    logic signed [PROD_W-1:0]  c2_reg [3];
    logic signed [PPROD_W-1:0] p1_reg [3];
    logic signed [PPROD_W-1:0] p2_reg [3];
    logic signed [DIFF_W-1:0]  dy_b_reg [3];
    logic signed [DIFF_W-1:0]  dx_b_reg [3];
    logic signed [JAC_W-1:0]   jac_b_reg;

    // Stage C: magnitudes and signs ready for division.
    logic                      vc_reg;
    front_out_t                fo_reg;
    front_out_t                fo_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < 3; gi++)
        begin : g_lane
            localparam int J = (gi + 1) % 3;
            localparam int K = (gi + 2) % 3;

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    vx_reg[gi]   <= vx[gi];
                    vy_reg[gi]   <= vy[gi];
                    dy_a_reg[gi] <= DIFF_W'(vy[J]) - DIFF_W'(vy[K]);
                    dx_a_reg[gi] <= DIFF_W'(vx[K]) - DIFF_W'(vx[J]);
                    c1_reg[gi]   <= PROD_W'(vx_reg[J]) * PROD_W'(vy_reg[K]);
                    c2_reg[gi]   <= PROD_W'(vx_reg[K]) * PROD_W'(vy_reg[J]);
                    p1_reg[gi]   <= PPROD_W'(dy_a_reg[gi]) * PPROD_W'(px_reg);
                    p2_reg[gi]   <= PPROD_W'(dx_a_reg[gi]) * PPROD_W'(py_reg);
                    dy_b_reg[gi] <= dy_a_reg[gi];
                    dx_b_reg[gi] <= dx_a_reg[gi];
                end
            end

            logic signed [SUM_W-1:0]  sum;
            logic [SUM_W-1:0]         sum_abs;
            logic [DIFF_W-1:0]        dy_abs, dx_abs;

            always_comb
            begin
                sum = SUM_W'(c1_reg[gi]) - SUM_W'(c2_reg[gi])
                    + SUM_W'(p1_reg[gi]) + SUM_W'(p2_reg[gi]);
                sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
                dy_abs  = dy_b_reg[gi][DIFF_W-1] ? DIFF_W'(-dy_b_reg[gi])
                                                 : DIFF_W'(dy_b_reg[gi]);
                dx_abs  = dx_b_reg[gi][DIFF_W-1] ? DIFF_W'(-dx_b_reg[gi])
                                                 : DIFF_W'(dx_b_reg[gi]);
                fo_next.num_mag[gi] = {sum_abs[MAG_W-1:0], {SHAPE_SHIFT{1'b0}}};
                fo_next.neg[gi]     = sum[SUM_W-1] ^ jac_b_reg[JAC_W-1];
                fo_next.num_mag[SHAPE_LANES + 2*gi] =
                    {{(NUM_W-DIFF_W-DERIV_SHIFT){1'b0}}, dy_abs, {DERIV_SHIFT{1'b0}}};
                fo_next.neg[SHAPE_LANES + 2*gi] = dy_b_reg[gi][DIFF_W-1] ^ jac_b_reg[JAC_W-1];
                fo_next.num_mag[SHAPE_LANES + 2*gi + 1] =
                    {{(NUM_W-DIFF_W-DERIV_SHIFT){1'b0}}, dx_abs, {DERIV_SHIFT{1'b0}}};
                fo_next.neg[SHAPE_LANES + 2*gi + 1] = dx_b_reg[gi][DIFF_W-1] ^ jac_b_reg[JAC_W-1];
            end
        end
    endgenerate

    always_comb
    begin
        fo_next.den  = jac_b_reg[JAC_W-1] ? DEN_W'(~jac_b_reg + 1'b1) : DEN_W'(jac_b_reg);
        fo_next.zero = (jac_b_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= px;
            py_reg    <= py;
            jac_a_reg <= jac;
            jac_b_reg <= jac_a_reg;
            fo_reg    <= fo_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_data  = fo_reg;

endmodule

// ===== hw/rtl/bsf_div.sv =====
module bsf_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                in_valid,
    input  bsf_pkg::front_out_t in_data,
    output logic                out_valid,
    output bsf_pkg::div_out_t   out_data
);
    import bsf_pkg::*;

    // Stage 0 checks for quotient overflow and loads the partial remainder;
    // each following stage retires BITS_PER_STAGE quotient bits.
    logic             v_reg    [DIV_STAGES+1];
    div_lane_t        lane_reg [DIV_STAGES+1][LANES];
    logic [DEN_W-1:0] den_reg  [DIV_STAGES+1];
    logic             zero_reg [DIV_STAGES+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    genvar gl, gs;
    generate
        for (gl = 0; gl < LANES; gl++)
        begin : g_init
            logic [NUM_W-OUT_W-1:0] top;
            logic                   ovf;
            assign top = in_data.num_mag[gl][NUM_W-1:OUT_W];
            assign ovf = ({{(DEN_W-(NUM_W-OUT_W)){1'b0}}, top} >= in_data.den);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    lane_reg[0][gl].rem  <= ovf ? '0 : {{(DEN_W-(NUM_W-OUT_W)){1'b0}}, top};
                    lane_reg[0][gl].word <= in_data.num_mag[gl][OUT_W-1:0];
                    lane_reg[0][gl].ovf  <= ovf;
                    lane_reg[0][gl].neg  <= in_data.neg[gl];
                end
            end
        end

        for (gs = 1; gs <= DIV_STAGES; gs++)
        begin : g_stage
            for (gl = 0; gl < LANES; gl++)
            begin : g_l
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        lane_reg[gs][gl] <= div_step(lane_reg[gs-1][gl], den_reg[gs-1]);
                    end
                end
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    den_reg[gs]  <= den_reg[gs-1];
                    zero_reg[gs] <= zero_reg[gs-1];
                end
            end
        end

        for (gl = 0; gl < LANES; gl++)
        begin : g_out
            assign out_data.word[gl] = lane_reg[DIV_STAGES][gl].word;
            assign out_data.ovf[gl]  = lane_reg[DIV_STAGES][gl].ovf;
            assign out_data.neg[gl]  = lane_reg[DIV_STAGES][gl].neg;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg[0]  <= in_data.den;
            zero_reg[0] <= in_data.zero;
        end
    end

    assign out_data.zero = zero_reg[DIV_STAGES];
    assign out_valid     = v_reg[DIV_STAGES];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bsf_pkg::*;

    // Clock and reset.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    bsf_in_if  sample ();
    bsf_out_if result ();

    triangle_barycentric_shape_functions i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    // One expected result of the shape-function block.
    typedef struct {
        logic signed [OUT_W-1:0] val[9];
        logic                    zero;
    } shape_result_t;

    typedef struct {
        logic signed [COORD_W-1:0] vx[3];
        logic signed [COORD_W-1:0] vy[3];
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [JAC_W-1:0]   jac;
    } triangle_item_t;

    shape_result_t expected_shapes[$];
    int            error_count = 0;
    int            idle_cycles = 0;
    bit            sink_hold = 1'b0;  // long receiver hold-off, driven by its own process

    // Scaled quotient: num * 2^shift / den, truncated toward zero, then saturated
    // to the signed 32-bit range. Numerators here stay well below 2^40, and the
    // shift is at most 23, so 80-bit magnitudes cannot overflow.
    function automatic logic signed [OUT_W-1:0] scaled_quotient(
        input longint num, input longint den, input int shift);
        logic [79:0] n_mag;
        logic [79:0] d_mag;
        logic [79:0] q;
        logic [79:0] lim;
        bit          neg;
        neg   = (num < 0) != (den < 0);
        n_mag = (num < 0) ? 80'(-num) : 80'(num);
        d_mag = (den < 0) ? 80'(-den) : 80'(den);
        n_mag = n_mag << shift;
        q     = n_mag / d_mag;
        lim   = neg ? (80'd1 << (OUT_W - 1)) : ((80'd1 << (OUT_W - 1)) - 1);
        if (q > lim)
            q = lim;
        if (neg)
            q = -q;
        return q[OUT_W-1:0];
    endfunction

    // Predicts the barycentric shape values and their constant derivatives.
    function automatic shape_result_t predict_shapes(input triangle_item_t t);
        shape_result_t r;
        longint        xj, yj, xk, yk, ddx, ddy, num;
        int            j, k;
        for (int i = 0; i < 9; i++)
            r.val[i] = '0;
        r.zero = 1'b0;
        if (t.jac == 0)
        begin
            r.zero = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++)
        begin
            j   = (i + 1) % 3;
            k   = (i + 2) % 3;
            xj  = t.vx[j];
            yj  = t.vy[j];
            xk  = t.vx[k];
            yk  = t.vy[k];
            ddy = yj - yk;
            ddx = xk - xj;
            num = xj * yk - xk * yj + ddy * longint'(t.px) + ddx * longint'(t.py);
            r.val[i]         = scaled_quotient(num, t.jac, SHAPE_SHIFT);
            r.val[3 + 2 * i] = scaled_quotient(ddy, t.jac, DERIV_SHIFT);
            r.val[4 + 2 * i] = scaled_quotient(ddx, t.jac, DERIV_SHIFT);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Gap length: mostly short, now and then long.
    function automatic int random_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        else if (roll < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Sends one item, with a random gap before it, and records its prediction.
    task automatic send_triangle(input triangle_item_t t);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid         <= 1'b1;
        sample.vert0_x       <= t.vx[0];
        sample.vert0_y       <= t.vy[0];
        sample.vert1_x       <= t.vx[1];
        sample.vert1_y       <= t.vy[1];
        sample.vert2_x       <= t.vx[2];
        sample.vert2_y       <= t.vy[2];
        sample.point_x       <= t.px;
        sample.point_y       <= t.py;
        sample.area_jacobian <= t.jac;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        expected_shapes.push_back(predict_shapes(t));
    endtask

    // A random coordinate, biased now and then toward the extremes.
    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3, 4: return COORD_W'($urandom_range(2047) - 1024);
            default: return COORD_W'($urandom());
        endcase
    endfunction

    function automatic logic signed [JAC_W-1:0] random_jacobian();
        case ($urandom_range(11))
            0: return 32'sh0;
            1: return 32'sh80000000;
            2: return 32'sh7fffffff;
            3: return $urandom_range(3) + 1;
            4: return -($urandom_range(3) + 1);
            5, 6: return $urandom_range(32'h00ffffff) - 32'h00800000;
            default: return $urandom();
        endcase
    endfunction

    function automatic triangle_item_t random_triangle();
        triangle_item_t t;
        for (int i = 0; i < 3; i++)
        begin
            t.vx[i] = random_coord();
            t.vy[i] = random_coord();
        end
        t.px  = random_coord();
        t.py  = random_coord();
        t.jac = random_jacobian();
        return t;
    endfunction

    function automatic triangle_item_t make_triangle(
        input int x0, input int y0, input int x1, input int y1, input int x2,
        input int y2, input int px, input int py, input int jac);
        triangle_item_t t;
        t.vx[0] = COORD_W'(x0); t.vy[0] = COORD_W'(y0);
        t.vx[1] = COORD_W'(x1); t.vy[1] = COORD_W'(y1);
        t.vx[2] = COORD_W'(x2); t.vy[2] = COORD_W'(y2);
        t.px = COORD_W'(px); t.py = COORD_W'(py); t.jac = jac;
        return t;
    endfunction

    // Directed: a unit right triangle, zero Jacobian, negative Jacobian,
    // extreme coordinates with tiny Jacobians for saturation both ways.
    task automatic test_directed();
        // Unit triangle in Q8.8 with J = 0.5 in Q16.16, point at the centroid.
        send_triangle(make_triangle(0, 0, 256, 0, 0, 256, 85, 85, 32'h8000));
        send_triangle(make_triangle(0, 0, 256, 0, 0, 256, 0, 0, 32'h8000));
        send_triangle(make_triangle(0, 0, 256, 0, 0, 256, 85, 85, -32'sh8000));
        send_triangle(make_triangle(100, 200, 300, 400, 500, 600, 7, 9, 0));
        send_triangle(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767,
                                    32767, 32767, 1));
        send_triangle(make_triangle(-32768, -32768, 32767, -32768, -32768, 32767,
                                    -32768, -32768, -1));
        send_triangle(make_triangle(32767, 32767, -32768, 32767, 32767, -32768,
                                    -32768, 32767, 32'sh7fffffff));
        send_triangle(make_triangle(32767, -32768, -32768, 32767, 0, 0,
                                    32767, -32768, 32'sh80000000));
        send_triangle(make_triangle(-1, -1, -1, -1, -1, -1, -1, -1, 32'hffffffff));
        send_triangle(make_triangle(1, 2, 3, 4, 5, 6, 7, 8, 0));
        send_triangle(make_triangle(512, -256, -512, 256, 1024, 768, 40, -40, 32'h30000));
        send_triangle(make_triangle(32767, 32767, 32767, 32767, 32767, 32767,
                                    32767, 32767, 2));
    endtask

    // Random streaming with random gaps on both sides.
    task automatic test_random_stream(input int count);
        for (int n = 0; n < count; n++)
            send_triangle(random_triangle());
    endtask

    // Receiver holds off in its own process while items keep coming back to back,
    // so the pipeline fills and the input stalls.
    task automatic test_backpressure();
        fork
            begin
                sink_hold <= 1'b1;
                repeat (200) @(posedge clk);
                sink_hold <= 1'b0;
            end
            begin
                for (int n = 0; n < 60; n++)
                    send_triangle_now(random_triangle());
            end
        join
    endtask

    // Like send_triangle but with no gap, to keep the input saturated.
    task automatic send_triangle_now(input triangle_item_t t);
        sample.valid         <= 1'b1;
        sample.vert0_x       <= t.vx[0];
        sample.vert0_y       <= t.vy[0];
        sample.vert1_x       <= t.vx[1];
        sample.vert1_y       <= t.vy[1];
        sample.vert2_x       <= t.vx[2];
        sample.vert2_y       <= t.vy[2];
        sample.point_x       <= t.px;
        sample.point_y       <= t.py;
        sample.area_jacobian <= t.jac;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        expected_shapes.push_back(predict_shapes(t));
    endtask

    // Receiver ready: random stalls, held low entirely during the hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (sink_hold)
            result.ready <= 1'b0;
        else
            result.ready <= ($urandom_range(99) < 70) || ($urandom_range(99) < 50);
    end

    // Checks each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        shape_result_t want;
        logic [OUT_W-1:0] got[9];
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.shape0, result.shape1, result.shape2,
                    result.dshape0_dx, result.dshape0_dy, result.dshape1_dx,
                    result.dshape1_dy, result.dshape2_dx, result.dshape2_dy};
            if (expected_shapes.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_shapes.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.val[i])
                        report_mismatch($sformatf("field %0d", i), got[i], want.val[i]);
                if (result.zero_divisor !== want.zero)
                    report_mismatch("zero_divisor", OUT_W'(result.zero_divisor),
                                    OUT_W'(want.zero));
            end
        end
    end

    // Watchdog: counts cycles in which nothing is accepted on either side.
    // The long hold-off stays well within the limit.
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("triangle_barycentric_shape_functions test failed");
            $finish;
        end
    end

    initial
    begin
        sample.valid         = 1'b0;
        sample.vert0_x       = '0;
        sample.vert0_y       = '0;
        sample.vert1_x       = '0;
        sample.vert1_y       = '0;
        sample.vert2_x       = '0;
        sample.vert2_y       = '0;
        sample.point_x       = '0;
        sample.point_y       = '0;
        sample.area_jacobian = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_stream(500);
        test_backpressure();
        test_random_stream(530);
        sample.valid <= 1'b0;

        while (expected_shapes.size() != 0)
            @(posedge clk);
        // Let any stray result emerge.
        repeat (80) @(posedge clk);

        if (error_count == 0)
            $display("triangle_barycentric_shape_functions test passed");
        else
            $display("triangle_barycentric_shape_functions test failed");
        $finish;
    end
endmodule

// ===== triangle_barycentric_shape_functions.f =====
hw/rtl/bsf_pkg.sv
hw/rtl/bsf_if.sv
hw/rtl/bsf_front.sv
hw/rtl/bsf_div.sv
hw/rtl/triangle_barycentric_shape_functions.sv
tb/tb_top.sv
